>>> rtl/multilevel_feedback_queue_scheduler_core_assert.svh
// Assertion macros for the scheduler core checker
`ifndef MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_CORE_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_CORE_ASSERT_SVH
`define MFQ_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("mfq check failed");
`define MFQ_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("mfq check failed");
`endif

>>> rtl/mfq_pkg.sv
// Shared types and codes of the multilevel feedback queue scheduler
`timescale 1ns / 1ps
package mfq_pkg;
    typedef enum logic [1:0] {
        CMD_INSERT   = 2'd0,
        CMD_SCHEDULE = 2'd1,
        CMD_REMOVE   = 2'd2,
        CMD_NONE     = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_IDLE     = 2'd3
    } t_status;

    localparam logic [2:0] REG_POLICY = 3'd0;
    localparam logic [2:0] REG_LEVELS = 3'd1;
    localparam logic [2:0] REG_Q0     = 3'd2;
    localparam logic [2:0] REG_Q3     = 3'd5;

    // operation broadcast to every slot cell
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_SHIFT  = 2'd1,
        OP_APPEND = 2'd2
    } t_op;

    // per-level control driven to the cell chain
    typedef struct packed {
        t_op        op;
        logic [8:0] pos;
    } t_lvl_ctl;
endpackage

>>> rtl/mfq_cell.sv
// One queue slot cell: holds an id, takes its neighbour's on a shift and the new id on an append
`timescale 1ns / 1ps
module mfq_cell #(
    parameter int ID_BITS = 10,
    parameter int POS     = 0
) (
    input  logic                  i_clk,
    input  mfq_pkg::t_lvl_ctl     i_ctl,
    input  logic [ID_BITS-1:0]    i_next_id,
    input  logic [ID_BITS-1:0]    i_new_id,
    output logic [ID_BITS-1:0]    o_id
);
    import mfq_pkg::*;

    logic [ID_BITS-1:0] r_id;
    logic [ID_BITS-1:0] n_id;

    always_comb begin
        n_id = r_id;
        case (i_ctl.op)
            OP_SHIFT:  if (i_ctl.pos <= 9'(POS)) n_id = i_next_id;
            OP_APPEND: if (i_ctl.pos == 9'(POS)) n_id = i_new_id;
            default:   n_id = r_id;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_id <= n_id;
    end

    assign o_id = r_id;
endmodule

>>> rtl/mfq_level.sv
// One priority level: a chain of slot cells, oldest at position 0
`timescale 1ns / 1ps
module mfq_level #(
    parameter int SLOTS   = 16,
    parameter int ID_BITS = 10
) (
    input  logic                        i_clk,
    input  mfq_pkg::t_lvl_ctl           i_ctl,
    input  logic [ID_BITS-1:0]          i_new_id,
    output logic [SLOTS-1:0][ID_BITS-1:0] o_ids
);
    import mfq_pkg::*;

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_cell
            logic [ID_BITS-1:0] w_next;
            if (g == SLOTS - 1) begin : g_end
                assign w_next = o_ids[g];
            end else begin : g_mid
                assign w_next = o_ids[g+1];
            end
            mfq_cell #(.ID_BITS(ID_BITS), .POS(g)) u_cell (
                .i_clk     (i_clk),
                .i_ctl     (i_ctl),
                .i_next_id (w_next),
                .i_new_id  (i_new_id),
                .o_id      (o_ids[g])
            );
        end
    endgenerate
endmodule

>>> rtl/multilevel_feedback_queue_scheduler_core.sv
// Top level of the multilevel feedback queue scheduler
//  channel | signals                                   | direction
//  cmd     | i_start, o_busy, i_command..i_run_ticks   | in
//  result  | o_done, o_chosen_valid..o_status          | out
//  config  | i_cfg_valid, o_cfg_ready, i_cfg_index/data| in
// A remove, or a schedule of a runnable current process, is
// scanned one slot a cycle, level by level, before the queues are
// updated. Reset sets counts, control and config registers only.
// The result strobe lasts one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
module multilevel_feedback_queue_scheduler_core #(
    parameter int LEVELS          = 4,
    parameter int SLOTS_PER_LEVEL = 16,
    parameter int ID_BITS         = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [1:0]         i_command,
    input  logic [ID_BITS-1:0] i_process_id,
    input  logic               i_current_valid,
    input  logic               i_current_runnable,
    input  logic [ID_BITS-1:0] i_current_id,
    input  logic [15:0]        i_run_ticks,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    output logic               o_done,
    output logic               o_chosen_valid,
    output logic [ID_BITS-1:0] o_chosen_id,
    output logic [1:0]         o_chosen_level,
    output logic [7:0]         o_quantum_out,
    output logic [1:0]         o_placed_level,
    output logic [1:0]         o_status
);
    import mfq_pkg::*;

    localparam int LB = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CB = $clog2(SLOTS_PER_LEVEL + 1);
    localparam int PB = (SLOTS_PER_LEVEL > 1) ? $clog2(SLOTS_PER_LEVEL) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_SHIFT, S_APPEND, S_PICK, S_POP, S_DONE
    } t_state;

    t_state r_state;
    logic              r_policy;
    logic [2:0]        r_nlev_cfg;
    logic [7:0]        r_quant [4];
    logic [1:0]        r_cmd;
    logic [ID_BITS-1:0] r_pid, r_cid;
    logic [15:0]       r_ticks;
    logic [CB-1:0]     r_count [LEVELS];
    logic [LB-1:0]     r_lv;
    logic [CB-1:0]     r_pos;
    logic              r_found;
    logic [LB-1:0]     r_flv;
    logic [PB-1:0]     r_fpos;
    logic [LB-1:0]     r_target;
    logic [ID_BITS-1:0] r_new_id;
    logic              r_append;
    logic              r_do_shift;
    logic              r_cvld;
    logic [ID_BITS-1:0] r_chid;
    logic [LB-1:0]     r_chlv;
    logic [7:0]        r_qout;
    logic [LB-1:0]     r_placed;
    t_status           r_status;

    t_lvl_ctl w_ctl [LEVELS];
    logic [SLOTS_PER_LEVEL-1:0][ID_BITS-1:0] w_ids [LEVELS];

    logic [LB:0] w_nlev;
    always_comb begin
        if (!r_policy) w_nlev = (LB+1)'(1);
        else if (r_nlev_cfg == 3'd0) w_nlev = (LB+1)'(1);
        else if (32'(r_nlev_cfg) > LEVELS) w_nlev = (LB+1)'(LEVELS);
        else w_nlev = (LB+1)'(r_nlev_cfg);
    end

    function automatic logic [7:0] quant_of(input logic [LB-1:0] lv,
                                            input logic [7:0] q [4]);
        logic [7:0] v;
        v = q[3];
        if (32'(lv) < 3) v = q[lv[1:0]];
        return v;
    endfunction

    genvar g;
    generate
        for (g = 0; g < LEVELS; g++) begin : g_lvl
            mfq_level #(.SLOTS(SLOTS_PER_LEVEL), .ID_BITS(ID_BITS)) u_level (
                .i_clk    (i_clk),
                .i_ctl    (w_ctl[g]),
                .i_new_id (r_new_id),
                .o_ids    (w_ids[g])
            );
        end
    endgenerate

    always_comb begin
        for (int l = 0; l < LEVELS; l++) begin
            w_ctl[l].op  = OP_HOLD;
            w_ctl[l].pos = '0;
            if (r_state == S_SHIFT && r_do_shift && r_flv == LB'(l)) begin
                w_ctl[l].op  = OP_SHIFT;
                w_ctl[l].pos = 9'(r_fpos);
            end
            if (r_state == S_POP && r_chlv == LB'(l)) begin
                w_ctl[l].op  = OP_SHIFT;
                w_ctl[l].pos = '0;
            end
            if (r_state == S_APPEND && r_append && r_target == LB'(l)) begin
                w_ctl[l].op  = OP_APPEND;
                w_ctl[l].pos = 9'(r_count[l]);
            end
        end
    end

    logic [ID_BITS-1:0] w_key;
    assign w_key = (r_cmd == CMD_REMOVE) ? r_pid : r_cid;
    logic w_hit;
    assign w_hit = (r_pos < r_count[r_lv]) &&
                   (w_ids[r_lv][r_pos[PB-1:0]] == w_key);
    logic w_lv_last;
    assign w_lv_last = ({1'b0, r_lv} + 1'b1) >= w_nlev;

    // placement level for a process not already queued
    logic [LB-1:0] w_fresh;
    always_comb begin
        logic stop;
        w_fresh = '0;
        stop = 1'b0;
        if (r_ticks != 16'd0) begin
            for (int i = 0; i < LEVELS - 1; i++) begin
                if (!stop && (i + 1) < int'(w_nlev)) begin
                    if (r_ticks >= 16'(quant_of(LB'(i), r_quant)))
                        w_fresh = LB'(i + 1);
                    else stop = 1'b1;
                end
            end
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !i_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_policy   <= 1'b0;
            r_nlev_cfg <= 3'd1;
            for (int i = 0; i < 4; i++) r_quant[i] <= 8'd10;
            for (int i = 0; i < LEVELS; i++) r_count[i] <= '0;
            o_done     <= 1'b0;
            r_append   <= 1'b0;
            r_do_shift <= 1'b0;
        end else begin
            o_done <= (r_state == S_DONE);
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_POLICY) r_policy <= i_cfg_data[0];
                else if (i_cfg_index == REG_LEVELS) r_nlev_cfg <= i_cfg_data[2:0];
                else if (i_cfg_index >= REG_Q0 && i_cfg_index <= REG_Q3)
                    r_quant[2'(i_cfg_index - REG_Q0)] <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        logic rq;
                        rq = (t_cmd'(i_command) == CMD_INSERT) ||
                             (t_cmd'(i_command) == CMD_SCHEDULE && !r_policy &&
                              i_current_valid);
                        r_cmd <= i_command; r_pid <= i_process_id;
                        r_cid <= i_current_id; r_ticks <= i_run_ticks;
                        r_lv <= '0; r_pos <= '0; r_found <= 1'b0;
                        r_do_shift <= 1'b0;
                        r_append <= rq && (r_count[0] < CB'(SLOTS_PER_LEVEL));
                        r_status <= (rq && r_count[0] >= CB'(SLOTS_PER_LEVEL)) ?
                                    ST_FULL : ST_OK;
                        r_cvld <= 1'b0; r_chid <= '0; r_chlv <= '0;
                        r_qout <= '0; r_placed <= '0;
                        r_new_id <= (t_cmd'(i_command) == CMD_SCHEDULE) ?
                                    i_current_id : i_process_id;
                        r_target <= '0;
                        case (t_cmd'(i_command))
                            CMD_INSERT:   r_state <= S_APPEND;
                            CMD_REMOVE:   r_state <= S_SCAN;
                            CMD_SCHEDULE: begin
                                if (!r_policy) r_state <= S_APPEND;
                                else if (i_current_valid && i_current_runnable)
                                    r_state <= S_SCAN;
                                else r_state <= S_PICK;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (w_hit) begin
                        r_found <= 1'b1; r_flv <= r_lv; r_fpos <= r_pos[PB-1:0];
                        r_state <= S_DECIDE;
                    end else if (r_pos + 1'b1 >= r_count[r_lv] ||
                                 r_pos >= r_count[r_lv]) begin
                        r_pos <= '0;
                        if (w_lv_last) r_state <= S_DECIDE;
                        else r_lv <= r_lv + 1'b1;
                    end else r_pos <= r_pos + 1'b1;
                end
                S_DECIDE: begin
                    if (r_cmd == CMD_REMOVE) begin
                        if (r_found) r_do_shift <= 1'b1;
                        else r_status <= ST_NOTFOUND;
                        r_state <= S_SHIFT;
                    end else if (r_found) begin
                        logic [LB-1:0] tg;
                        tg = r_flv;
                        if (r_ticks >= 16'(quant_of(r_flv, r_quant)) &&
                            ({1'b0, r_flv} + 1'b1) < w_nlev) tg = r_flv + 1'b1;
                        r_target <= tg;
                        if (tg != r_flv && r_count[tg] >= CB'(SLOTS_PER_LEVEL)) begin
                            r_status <= ST_FULL; r_placed <= r_flv;
                        end else begin
                            r_do_shift <= 1'b1; r_append <= 1'b1; r_placed <= tg;
                        end
                        r_state <= S_SHIFT;
                    end else begin
                        r_target <= w_fresh;
                        if (r_count[w_fresh] >= CB'(SLOTS_PER_LEVEL))
                            r_status <= ST_FULL;
                        else begin
                            r_append <= 1'b1; r_placed <= w_fresh;
                        end
                        r_state <= S_APPEND;
                    end
                end
                S_SHIFT: begin
                    if (r_do_shift) r_count[r_flv] <= r_count[r_flv] - 1'b1;
                    r_do_shift <= 1'b0;
                    r_state <= (r_cmd == CMD_REMOVE) ? S_DONE : S_APPEND;
                end
                S_APPEND: begin
                    if (r_append) r_count[r_target] <= r_count[r_target] + 1'b1;
                    r_append <= 1'b0;
                    if (r_cmd == CMD_SCHEDULE) begin
                        r_state <= S_PICK;
                        if (!r_policy) r_qout <= r_quant[0];
                    end else r_state <= S_DONE;
                end
                S_PICK: begin
                    logic hit;
                    hit = 1'b0;
                    for (int i = 0; i < LEVELS; i++) begin
                        if (!hit && i < int'(w_nlev) && r_count[i] != '0) begin
                            hit = 1'b1;
                            r_chlv <= LB'(i);
                            r_chid <= w_ids[i][0];
                            r_qout <= quant_of(LB'(i), r_quant);
                        end
                    end
                    r_cvld <= hit;
                    if (!hit && r_status == ST_OK) r_status <= ST_IDLE;
                    r_state <= hit ? S_POP : S_DONE;
                end
                S_POP: begin
                    r_count[r_chlv] <= r_count[r_chlv] - 1'b1;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_chosen_valid = r_cvld;
    assign o_chosen_id    = r_chid;
    assign o_chosen_level = 2'(r_chlv);
    assign o_quantum_out  = r_qout;
    assign o_placed_level = 2'(r_placed);
    assign o_status       = r_status;
endmodule

>>> rtl/mfq_checker.sv
// Port-level checker for the scheduler core, bound to the top level
`timescale 1ns / 1ps
`include "multilevel_feedback_queue_scheduler_core_assert.svh"
module mfq_port_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       o_busy,
    input logic       o_cfg_ready,
    input logic       o_done,
    input logic       o_chosen_valid,
    input logic [1:0] o_status
);
    import mfq_pkg::*;

    `MFQ_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    `MFQ_ASSERT_IMP(a_done_busy, i_clk, i_rst_n, o_done, !o_busy)
    `MFQ_ASSERT_IMP(a_cfg_idle, i_clk, i_rst_n, o_cfg_ready, !o_busy)
    `MFQ_ASSERT_IMP(a_pick_ok, i_clk, i_rst_n, o_done && o_chosen_valid,
        o_status != ST_IDLE && o_status != ST_NOTFOUND)
endmodule

bind multilevel_feedback_queue_scheduler_core mfq_port_checker u_mfq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .o_busy         (o_busy),
    .o_cfg_ready    (o_cfg_ready),
    .o_done         (o_done),
    .o_chosen_valid (o_chosen_valid),
    .o_status       (o_status)
);
